@@ rtl/tmf_pkg.sv @@
// ---------------------------------------------------------------------------
// tmf_pkg: shared types and constants
// Widths, fixed divisors and the group descriptor word passed from the
// front end to the back end of the trimmed-mean filter.
// ---------------------------------------------------------------------------
package tmf_pkg;

   localparam int SAMPLE_W       = 16;
   localparam int CNT_W          = 8;
   localparam int SUM_W          = 24;
   localparam int VAL_W          = 13;
   localparam int DIVISOR_W      = 8;
   localparam int BLOCKS_PER_SET = 5;
   localparam int BLK_IDX_W      = 3;
   localparam int TRIM_SUM_W     = 16;
   localparam int TRIM_COUNT     = 3;
   localparam int QUEUE_DEPTH    = 2;
   localparam int WINDOW_LEN_DEF = 7;

   localparam logic [CNT_W-1:0] SAMPLES_PER_BLOCK_RST = 8'd20;

   // Divide by 10 as multiply by ceil(2^27 / 10), exact for values below 2^26.
   localparam int              RECIP_SHIFT = 27;
   localparam int              PROD_W      = 2 * SUM_W;
   localparam logic [SUM_W-1:0] RECIP_10   = 24'd13421773;

   // Divide by 3 as multiply by ceil(2^17 / 3), exact for values below 2^17.
   localparam int              RECIP_3_SHIFT = 17;
   localparam int              RECIP_3_W     = 16;
   localparam int              TRIM_PROD_W   = TRIM_SUM_W + RECIP_3_W;
   localparam logic [RECIP_3_W-1:0] RECIP_3  = 16'd43691;

   // One closed group: its sum and the divisor in effect when it closed.
   typedef struct packed {
      logic [SUM_W-1:0]     sum;
      logic [DIVISOR_W-1:0] divisor;
   } grp_entry_type;

   // Queue status, read by the front end (full) and the back end (empty).
   typedef struct packed {
      logic empty;
      logic full;
   } q_status_type;

endpackage

@@ rtl/trimmed_mean_moving_average_filter_top.sv @@
// ---------------------------------------------------------------------------
// trimmed_mean_moving_average_filter_top: proximity sample filter
// Group averaging, five-value trimmed mean and moving window average.
// ---------------------------------------------------------------------------
// Each accepted 16-bit sample is added to a running group sum. When the group
// count reaches samples_per_block (0 counts as 1; reset value 20) the group
// sum is divided by the group size and by ten into a 13-bit block value.
// Every fifth block value closes a set: the smallest and largest are dropped,
// the middle three averaged, and that trimmed mean replaces the oldest entry
// of a WINDOW_LEN deep window that starts all zero. One result word, the
// truncated window mean, is emitted per set; all other samples give none.
// Timing: the front end takes one sample word per cycle as long as the
// two-entry group queue has room. For each closed group the back end pops
// it, runs 24 serial divide steps by the group size, waits for the divider's
// registered done flag, scales the quotient by ten and folds the value into
// the set. Every fifth group then goes on to divide by three, advance the
// window, divide the window sum and load the result register.
// The divides by ten, by three and by the window length are reciprocal
// multiplies; only the divide by the group size is serial. A finished result
// waits in an output register while the back end goes on with the next
// group; the load waits only while an earlier result word is still held.
// Write samples_per_block only while the block is idle; the change applies at
// once and keeps the partial group.
// ---------------------------------------------------------------------------
module trimmed_mean_moving_average_filter_top #(
   parameter int WINDOW_LEN = tmf_pkg::WINDOW_LEN_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [tmf_pkg::SAMPLE_W-1:0]  req_sample,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [tmf_pkg::VAL_W-1:0]     rsp_filtered_value,
   input  logic                          csr_wr_en,
   input  logic [tmf_pkg::CNT_W-1:0]     csr_wr_data
);
   import tmf_pkg::*;

   // group handoff between accumulator and sequencer
   q_status_type  q_status;
   grp_entry_type q_push_entry;
   grp_entry_type q_pop_entry;
   logic          q_push;
   logic          q_pop;

   // accumulate samples, close groups
   tmf_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_sample  (req_sample),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .q_status    (q_status),
      .q_push      (q_push),
      .q_entry     (q_push_entry)
   );

   // hold closed groups until the back end is free
   tmf_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_entry (q_push_entry),
      .pop        (q_pop),
      .pop_entry  (q_pop_entry),
      .status     (q_status)
   );

   // divide, trim, advance the window, emit
   tmf_back #(
      .WINDOW_LEN (WINDOW_LEN)
   ) u_back (
      .clock              (clock),
      .reset              (reset),
      .q_status           (q_status),
      .q_entry            (q_pop_entry),
      .q_pop              (q_pop),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_filtered_value (rsp_filtered_value)
   );

endmodule

@@ rtl/tmf_front.sv @@
// ---------------------------------------------------------------------------
// tmf_front: sample accumulator
// Sums incoming samples, closes a group once its count reaches the group
// size and hands the closed group to the queue.
// ---------------------------------------------------------------------------
module tmf_front (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [tmf_pkg::SAMPLE_W-1:0]  req_sample,
   input  logic                          csr_wr_en,
   input  logic [tmf_pkg::CNT_W-1:0]     csr_wr_data,
   input  tmf_pkg::q_status_type         q_status,
   output logic                          q_push,
   output tmf_pkg::grp_entry_type        q_entry
);
   import tmf_pkg::*;

   logic [CNT_W-1:0] spb_ff, spb_in;
   logic [SUM_W-1:0] sum_ff, sum_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [CNT_W-1:0] n_eff;
   logic [SUM_W-1:0] sum_next;
   logic [CNT_W-1:0] cnt_next;
   logic             accept;
   logic             close;

   assign req_ready = !q_status.full;
   assign accept    = req_valid && req_ready;
   // zero group size acts as one
   assign n_eff     = (spb_ff == '0) ? CNT_W'(1) : spb_ff;
   assign sum_next  = sum_ff + SUM_W'(req_sample);
   assign cnt_next  = cnt_ff + CNT_W'(1);
   assign close     = (cnt_next >= n_eff);

   assign q_push          = accept && close;
   assign q_entry.sum     = sum_next;
   assign q_entry.divisor = n_eff;

   always_comb begin
      spb_in = csr_wr_en ? csr_wr_data : spb_ff;
      sum_in = sum_ff;
      cnt_in = cnt_ff;
      if (accept) begin
         sum_in = close ? '0 : sum_next;
         cnt_in = close ? '0 : cnt_next;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         spb_ff <= SAMPLES_PER_BLOCK_RST;
         sum_ff <= '0;
         cnt_ff <= '0;
      end else begin
         spb_ff <= spb_in;
         sum_ff <= sum_in;
         cnt_ff <= cnt_in;
      end
   end

endmodule

@@ rtl/tmf_queue.sv @@
// ---------------------------------------------------------------------------
// tmf_queue: group descriptor queue
// Short register queue that decouples the accumulator from the back end.
// ---------------------------------------------------------------------------
module tmf_queue (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   input  tmf_pkg::grp_entry_type push_entry,
   input  logic                   pop,
   output tmf_pkg::grp_entry_type pop_entry,
   output tmf_pkg::q_status_type  status
);
   import tmf_pkg::*;

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int FILL_W = $clog2(QUEUE_DEPTH + 1);

   grp_entry_type       slot_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [FILL_W-1:0]   fill_ff, fill_in;

   function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
      return (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + PTR_W'(1);
   endfunction

   assign status.empty = (fill_ff == '0);
   assign status.full  = (fill_ff == FILL_W'(QUEUE_DEPTH));
   assign pop_entry    = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? ptr_inc(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = pop  ? ptr_inc(rd_ptr_ff) : rd_ptr_ff;
      fill_in   = fill_ff + FILL_W'(push) - FILL_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

@@ rtl/tmf_div.sv @@
// ---------------------------------------------------------------------------
// tmf_div: serial divider
// Restoring divider, one quotient bit per cycle; quotient holds until the
// next start.
// ---------------------------------------------------------------------------
module tmf_div (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [tmf_pkg::SUM_W-1:0]     dividend,
   input  logic [tmf_pkg::DIVISOR_W-1:0] divisor,
   output logic                          done,
   output logic [tmf_pkg::SUM_W-1:0]     quotient
);
   import tmf_pkg::*;

   localparam int STEP_W = $clog2(SUM_W);

   logic [SUM_W-1:0]     quo_ff, quo_in;
   logic [DIVISOR_W-1:0] rem_ff, rem_in;
   logic [DIVISOR_W-1:0] dsr_ff, dsr_in;
   logic [STEP_W-1:0]    step_ff, step_in;
   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [DIVISOR_W:0]   trial;
   logic                 fits;

   assign trial    = {rem_ff, quo_ff[SUM_W-1]};
   assign fits     = (trial >= {1'b0, dsr_ff});
   assign done     = done_ff;
   assign quotient = quo_ff;

   always_comb begin
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dsr_in  = dsr_ff;
      step_in = step_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         quo_in  = dividend;
         rem_in  = '0;
         dsr_in  = divisor;
         step_in = STEP_W'(SUM_W - 1);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in  = fits ? DIVISOR_W'(trial - {1'b0, dsr_ff}) : trial[DIVISOR_W-1:0];
         quo_in  = {quo_ff[SUM_W-2:0], fits};
         step_in = step_ff - STEP_W'(1);
         if (step_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      quo_ff  <= quo_in;
      rem_ff  <= rem_in;
      dsr_ff  <= dsr_in;
      step_ff <= step_in;
   end

endmodule

@@ rtl/tmf_back.sv @@
// ---------------------------------------------------------------------------
// tmf_back: block value, trimmed mean and window sequencer
// Turns each closed group into a block value, trims every set of five and
// keeps the moving window; drives the result register.
// ---------------------------------------------------------------------------
module tmf_back #(
   parameter int WINDOW_LEN = tmf_pkg::WINDOW_LEN_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   input  tmf_pkg::q_status_type      q_status,
   input  tmf_pkg::grp_entry_type     q_entry,
   output logic                       q_pop,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic [tmf_pkg::VAL_W-1:0]  rsp_filtered_value
);
   import tmf_pkg::*;

   localparam int WSUM_W      = VAL_W + $clog2(WINDOW_LEN + 1);
   // window divide as multiply by ceil(2^k / WINDOW_LEN); four spare bits
   // keep it exact for every window sum
   localparam int WIN_SHIFT   = WSUM_W + 4;
   localparam int WIN_RECIP_W = WIN_SHIFT + 1;
   localparam int WPROD_W     = WSUM_W + WIN_RECIP_W;
   localparam logic [WIN_RECIP_W-1:0] WIN_RECIP =
      WIN_RECIP_W'(((1 << WIN_SHIFT) + WINDOW_LEN - 1) / WINDOW_LEN);

   typedef enum logic [7:0] {
      ST_IDLE  = 8'b0000_0001,
      ST_DIVN  = 8'b0000_0010,
      ST_SCALE = 8'b0000_0100,
      ST_ACCUM = 8'b0000_1000,
      ST_DIV3  = 8'b0001_0000,
      ST_WIN   = 8'b0010_0000,
      ST_DIVW  = 8'b0100_0000,
      ST_WRITE = 8'b1000_0000
   } back_state_type;

   back_state_type         state_ff, state_in;
   logic [VAL_W-1:0]       bv_ff, bv_in;
   logic [BLK_IDX_W-1:0]   blk_ff, blk_in;
   logic [TRIM_SUM_W-1:0]  tot_ff, tot_in;
   logic [VAL_W-1:0]       lo_ff, lo_in;
   logic [VAL_W-1:0]       hi_ff, hi_in;
   logic [VAL_W-1:0]       tm_ff, tm_in;
   logic [VAL_W-1:0]       mean_ff, mean_in;
   logic [VAL_W-1:0]       win_ff [WINDOW_LEN];
   logic [WSUM_W-1:0]      wsum_ff, wsum_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [VAL_W-1:0]       rsp_data_ff, rsp_data_in;
   logic                   win_shift;
   logic [PROD_W-1:0]      prod;
   logic [TRIM_SUM_W-1:0]  trim_sum;
   logic [TRIM_PROD_W-1:0] trim_prod;
   logic [WPROD_W-1:0]     win_prod;
   logic [VAL_W-1:0]       win_new;

   logic                   div_start;
   logic [SUM_W-1:0]       div_dividend;
   logic [DIVISOR_W-1:0]   div_divisor;
   logic                   div_done;
   logic [SUM_W-1:0]       div_quot;

   tmf_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .done     (div_done),
      .quotient (div_quot)
   );

   assign div_dividend       = q_entry.sum;
   assign div_divisor        = q_entry.divisor;
   assign prod               = PROD_W'(div_quot) * PROD_W'(RECIP_10);
   assign trim_sum           = tot_ff - TRIM_SUM_W'(lo_ff) - TRIM_SUM_W'(hi_ff);
   assign trim_prod          = TRIM_PROD_W'(trim_sum) * TRIM_PROD_W'(RECIP_3);
   assign win_prod           = WPROD_W'(wsum_ff) * WPROD_W'(WIN_RECIP);
   assign win_new            = tm_ff;
   assign rsp_valid          = rsp_valid_ff;
   assign rsp_filtered_value = rsp_data_ff;

   always_comb begin
      state_in     = state_ff;
      bv_in        = bv_ff;
      blk_in       = blk_ff;
      tot_in       = tot_ff;
      lo_in        = lo_ff;
      hi_in        = hi_ff;
      tm_in        = tm_ff;
      mean_in      = mean_ff;
      wsum_in      = wsum_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_data_in  = rsp_data_ff;
      win_shift    = 1'b0;
      q_pop        = 1'b0;
      div_start    = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (!q_status.empty) begin
               q_pop     = 1'b1;
               div_start = 1'b1;
               state_in  = ST_DIVN;
            end
         end
         ST_DIVN: begin
            if (div_done) begin
               state_in = ST_SCALE;
            end
         end
         ST_SCALE: begin
            // divide by ten, keep 13 bits
            bv_in    = prod[RECIP_SHIFT +: VAL_W];
            state_in = ST_ACCUM;
         end
         ST_ACCUM: begin
            if (blk_ff == '0) begin
               tot_in = TRIM_SUM_W'(bv_ff);
               lo_in  = bv_ff;
               hi_in  = bv_ff;
            end else begin
               tot_in = tot_ff + TRIM_SUM_W'(bv_ff);
               lo_in  = (bv_ff < lo_ff) ? bv_ff : lo_ff;
               hi_in  = (bv_ff > hi_ff) ? bv_ff : hi_ff;
            end
            if (blk_ff == BLK_IDX_W'(BLOCKS_PER_SET - 1)) begin
               blk_in   = '0;
               state_in = ST_DIV3;
            end else begin
               blk_in   = blk_ff + BLK_IDX_W'(1);
               state_in = ST_IDLE;
            end
         end
         ST_DIV3: begin
            // drop min and max, divide the middle three by three
            tm_in    = trim_prod[RECIP_3_SHIFT +: VAL_W];
            state_in = ST_WIN;
         end
         ST_WIN: begin
            // drop the oldest, add the newest
            win_shift = 1'b1;
            wsum_in   = wsum_ff + WSUM_W'(win_new) - WSUM_W'(win_ff[0]);
            state_in  = ST_DIVW;
         end
         ST_DIVW: begin
            mean_in  = win_prod[WIN_SHIFT +: VAL_W];
            state_in = ST_WRITE;
         end
         ST_WRITE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = mean_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         blk_ff       <= '0;
         wsum_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         blk_ff       <= blk_in;
         wsum_ff      <= wsum_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      bv_ff       <= bv_in;
      tot_ff      <= tot_in;
      lo_ff       <= lo_in;
      hi_ff       <= hi_in;
      tm_ff       <= tm_in;
      mean_ff     <= mean_in;
      rsp_data_ff <= rsp_data_in;
   end

   // window starts all zero
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < WINDOW_LEN; i++) begin
            win_ff[i] <= '0;
         end
      end else if (win_shift) begin
         for (int i = 0; i < WINDOW_LEN - 1; i++) begin
            win_ff[i] <= win_ff[i + 1];
         end
         win_ff[WINDOW_LEN - 1] <= win_new;
      end
   end

endmodule
